### hdl/route_table_with_aging_defines.svh
// Assertion macros for the route table.
// Included by the top level; relies on clk and rst in the including scope.
`ifndef ROUTE_TABLE_WITH_AGING_DEFINES_SVH
`define ROUTE_TABLE_WITH_AGING_DEFINES_SVH
`define RTA_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define RTA_ASSERT_IMPLY(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
`endif

### hdl/rta_pkg.sv
// Types and codes for the route table with aging.
// No dependencies.
package rta_pkg;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_FIND   = 2'd1,
    CMD_PRUNE  = 2'd2,
    CMD_DELETE = 2'd3
  } cmd_t;

  localparam logic [CFG_IDX_W-1:0] REG_OWN_NODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 1'd1;

  typedef struct packed {
    logic [1:0]         command;
    logic [7:0]         dest_id;
    logic [7:0]         next_hop_id;
    logic [7:0]         mac_high;
    logic [7:0]         mac_low;
    logic [7:0]         hop_count;
    logic signed [15:0] signal_rssi;
    logic signed [15:0] noise_level;
    logic [3:0]         entry_index;
    logic [31:0]        now_time;
  } req_t;

  typedef struct packed {
    logic       found;
    logic [3:0] route_index;
    logic [4:0] entry_count;
    logic       dropped;
  } rsp_t;

  typedef struct packed {
    logic [7:0]         dest;
    logic [7:0]         next_hop;
    logic [7:0]         mac_high;
    logic [7:0]         mac_low;
    logic [7:0]         hop;
    logic signed [15:0] rssi;
    logic signed [15:0] noise;
    logic [31:0]        last_seen;
  } entry_t;
endpackage

### hdl/route_table_with_aging.sv
// Route table with aging: top level, holds the entry memory and sequencer.
// Depends on rta_pkg and route_table_with_aging_defines.svh.
//
// Every item walks the valid entries of the table one at a time (read in S_RD, then
// evaluate and write back in S_EV); an add that hits an existing destination stops
// early. Find, prune and delete compact the table in the same pass by copying kept
// entries down to a trailing write pointer. One item is in work at a time; the result
// sits in an output register, and the next item is taken while it waits. Configuration
// writes are taken at any time.
`include "route_table_with_aging_defines.svh"
module route_table_with_aging #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [rta_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                 cfg_data,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  rta_pkg::req_t               req,
  output logic                        rsp_valid,
  input  logic                        rsp_ready,
  output rta_pkg::rsp_t               rsp
);
  import rta_pkg::*;

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(TABLE_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RD   = 3'b010,
    S_EV   = 3'b100
  } state_t;

  state_t        state;
  req_t          item;
  logic [7:0]    own_node;
  logic [31:0]   timeout;
  logic [CW-1:0] count;
  logic [CW-1:0] rptr;
  logic [CW-1:0] wptr;
  logic          hit;
  logic          tail;
  logic          found;
  logic [IW-1:0] ridx;

  entry_t        mem [TABLE_DEPTH];
  entry_t        rd_data;
  logic          we;
  logic [IW-1:0] waddr;
  entry_t        wdata;

  entry_t        fresh;
  logic          done;
  logic          expired;
  logic          better;
  logic          key_match;
  logic          rsp_load;
  logic          add_miss;
  logic [CW-1:0] count_next;

  assign cfg_ready = 1'b1;
  assign req_ready = (state == S_IDLE);

  always_comb begin
    fresh.dest      = item.dest_id;
    fresh.next_hop  = item.next_hop_id;
    fresh.mac_high  = item.mac_high;
    fresh.mac_low   = item.mac_low;
    fresh.hop       = item.hop_count;
    fresh.rssi      = item.signal_rssi;
    fresh.noise     = item.noise_level;
    fresh.last_seen = item.now_time;
  end

  assign done      = hit || (rptr >= count);
  assign expired   = (rd_data.dest != own_node) &&
                     ((item.now_time - rd_data.last_seen) > timeout);
  assign better    = (item.hop_count < rd_data.hop) ||
                     ((item.hop_count == rd_data.hop) && (item.signal_rssi > rd_data.rssi));
  assign key_match = (rd_data.dest == item.dest_id);
  assign rsp_load  = (state == S_RD) && done && !(rsp_valid && !rsp_ready);
  assign add_miss  = (item.command == CMD_ADD) && !hit;

  always_comb begin
    count_next = wptr;
    if (item.command == CMD_ADD) begin
      count_next = count;
      if (!hit && count < FULL) begin
        count_next = count + 1'b1;
      end
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = wptr[IW-1:0];
    wdata = rd_data;
    if (rsp_load && add_miss && count < FULL) begin
      we    = 1'b1;
      waddr = count[IW-1:0];
      wdata = fresh;
    end else if (state == S_EV) begin
      unique case (item.command)
        CMD_ADD: begin
          if (key_match) begin
            we    = 1'b1;
            waddr = rptr[IW-1:0];
            wdata = better ? fresh : rd_data;
            wdata.dest      = rd_data.dest;
            wdata.last_seen = item.now_time;
          end
        end
        CMD_FIND: begin
          if (tail || !expired) begin
            we = 1'b1;
            if (!tail && key_match && rd_data.next_hop != own_node) begin
              wdata.last_seen = item.now_time;
            end
          end
        end
        CMD_PRUNE: we = !expired;
        CMD_DELETE: we = ({{(32-CW){1'b0}}, rptr} != {28'd0, item.entry_index});
        default: we = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data <= mem[rptr[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      own_node  <= 8'd0;
      timeout   <= 32'd60000;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_OWN_NODE: own_node <= cfg_data[7:0];
        REG_TIMEOUT:  timeout  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
      rptr      <= '0;
      wptr      <= '0;
      hit       <= 1'b0;
      tail      <= 1'b0;
      found     <= 1'b0;
      ridx      <= '0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            item  <= req;
            rptr  <= '0;
            wptr  <= '0;
            hit   <= 1'b0;
            tail  <= 1'b0;
            found <= 1'b0;
            ridx  <= '0;
            state <= S_RD;
          end
        end
        S_RD: begin
          if (done) begin
            if (rsp_load) begin
              rsp.found       <= found;
              rsp.route_index <= 4'(ridx);
              rsp.entry_count <= 5'(count_next);
              rsp.dropped     <= add_miss && (count >= FULL);
              count           <= count_next;
              state           <= S_IDLE;
            end
          end else begin
            state <= S_EV;
          end
        end
        S_EV: begin
          rptr  <= rptr + 1'b1;
          state <= S_RD;
          if (item.command == CMD_ADD) begin
            hit <= key_match;
          end else if (we) begin
            wptr <= wptr + 1'b1;
          end
          if (item.command == CMD_FIND && !tail && !expired && key_match &&
              rd_data.next_hop != own_node) begin
            tail  <= 1'b1;
            found <= 1'b1;
            ridx  <= wptr[IW-1:0];
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `RTA_ASSERT_ALWAYS(a_count_range, count <= FULL, "entry count beyond table depth")
  `RTA_ASSERT_ALWAYS(a_write_behind, wptr <= rptr, "compaction write passed read")
  `RTA_ASSERT_IMPLY(a_drop_full, rsp_valid && rsp.dropped, count == FULL, "drop while not full")
  `RTA_ASSERT_IMPLY(a_found_idx, rsp_valid && rsp.found, 5'(rsp.route_index) < rsp.entry_count,
                    "found index outside table")
endmodule

### sim/testbench.sv
// Self-checking testbench for the route table with aging: random and directed
// add, find, prune and delete items checked against a behavioral table model.
// Depends on rta_pkg and the route_table_with_aging RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rta_pkg::*;

  class route_scoreboard;
    entry_t table_q[$];
    logic [7:0] own_id;
    logic [31:0] timeout;
    rsp_t pending[$];
    int errors;

    function new();
      own_id = '0;
      timeout = 32'd60000;
      errors = 0;
    endfunction

    function bit aged(entry_t e, logic [31:0] now);
      logic [31:0] age;
      age = now - e.last_seen;
      return e.dest != own_id && age > timeout;
    endfunction

    function void note_item(req_t r);
      rsp_t o;
      entry_t e;
      bit hit;
      int i;
      o = '0;
      hit = 0;
      case (cmd_t'(r.command))
        CMD_ADD: begin
          foreach (table_q[k]) begin
            if (!hit && table_q[k].dest == r.dest_id) begin
              hit = 1;
              if (r.hop_count < table_q[k].hop || (r.hop_count == table_q[k].hop &&
                  r.signal_rssi > table_q[k].rssi)) begin
                table_q[k].next_hop = r.next_hop_id;
                table_q[k].mac_high = r.mac_high;
                table_q[k].mac_low = r.mac_low;
                table_q[k].hop = r.hop_count;
                table_q[k].rssi = r.signal_rssi;
                table_q[k].noise = r.noise_level;
              end
              table_q[k].last_seen = r.now_time;
            end
          end
          if (!hit) begin
            if (table_q.size() >= 16) begin
              o.dropped = 1;
            end else begin
              e = '{r.dest_id, r.next_hop_id, r.mac_high, r.mac_low, r.hop_count,
                    r.signal_rssi, r.noise_level, r.now_time};
              table_q.push_back(e);
            end
          end
        end
        CMD_FIND, CMD_PRUNE: begin
          i = 0;
          while (i < table_q.size()) begin
            if (aged(table_q[i], r.now_time)) begin
              table_q.delete(i);
            end else if (r.command == CMD_FIND && table_q[i].dest == r.dest_id &&
                         table_q[i].next_hop != own_id) begin
              table_q[i].last_seen = r.now_time;
              o.found = 1;
              o.route_index = 4'(i);
              break;
            end else begin
              i++;
            end
          end
        end
        default: begin
          if (r.entry_index < table_q.size()) table_q.delete(r.entry_index);
        end
      endcase
      o.entry_count = 5'(table_q.size());
      pending.push_back(o);
    endfunction

    function void check_result(rsp_t a);
      rsp_t x;
      if (pending.size() == 0) begin
        $error("result with nothing expected: %h", a);
        errors++;
        return;
      end
      x = pending.pop_front();
      if (a.found !== x.found) begin
        $error("found exp %0d got %0d", x.found, a.found);
        errors++;
      end
      if (a.route_index !== x.route_index) begin
        $error("route_index exp %0d got %0d", x.route_index, a.route_index);
        errors++;
      end
      if (a.entry_count !== x.entry_count) begin
        $error("entry_count exp %0d got %0d", x.entry_count, a.entry_count);
        errors++;
      end
      if (a.dropped !== x.dropped) begin
        $error("dropped exp %0d got %0d", x.dropped, a.dropped);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic req_valid = 0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 0;
  rsp_t rsp;

  route_scoreboard sb = new();
  int send_idle = 0;
  int recv_stall = 0;
  int quiet_cycles = 0;
  logic [31:0] clock_now = 0;

  route_table_with_aging dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && rsp_ready) sb.check_result(rsp);
      rsp_ready <= ($urandom_range(99) >= recv_stall);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 20000) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    if (idx == REG_OWN_NODE) sb.own_id = val[7:0];
    else sb.timeout = val;
    @(posedge clk);
  endtask

  task automatic send_item(req_t r);
    while ($urandom_range(99) < send_idle) @(posedge clk);
    req_valid <= 1;
    req <= r;
    do @(posedge clk); while (!req_ready);
    sb.note_item(r);
    req_valid <= 0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic req_t make_item(logic [1:0] cmd, logic [7:0] dst);
    req_t r;
    r.command = cmd;
    r.dest_id = dst;
    r.next_hop_id = ($urandom_range(3) == 0) ? sb.own_id : 8'($urandom);
    r.mac_high = 8'($urandom);
    r.mac_low = 8'($urandom);
    r.hop_count = ($urandom_range(1)) ? 8'($urandom_range(3)) : 8'($urandom);
    r.signal_rssi = 16'($urandom);
    r.noise_level = 16'($urandom);
    r.entry_index = 4'($urandom);
    r.now_time = clock_now;
    return r;
  endfunction

  task automatic random_phase(int count, logic [7:0] id_span);
    req_t r;
    int pick;
    repeat (count) begin
      clock_now = clock_now + (($urandom_range(9) == 0) ? $urandom : $urandom_range(40));
      pick = $urandom_range(99);
      r = make_item(pick < 55 ? CMD_ADD : pick < 80 ? CMD_FIND : pick < 88 ? CMD_PRUNE
                    : CMD_DELETE, ($urandom_range(9) == 0) ? 8'($urandom)
                    : 8'($urandom_range(id_span)));
      send_item(r);
    end
  endtask

  initial begin
    req_t r;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: fill past capacity, extremes, all commands
    clock_now = 32'hFFFF_FFF0;
    for (int i = 0; i < 17; i++) begin
      r = make_item(CMD_ADD, (i == 0) ? 8'd0 : (i == 16) ? 8'd200 : 8'(255 - i));
      r.hop_count = (i == 1) ? 8'd255 : 8'd5;
      r.signal_rssi = (i == 2) ? 16'sh8000 : 16'sh7FFF;
      r.noise_level = (i == 2) ? 16'sh7FFF : 16'sh8000;
      r.mac_high = (i == 3) ? 8'hFF : 8'h00;
      r.mac_low = (i == 3) ? 8'h00 : 8'hFF;
      send_item(r);
    end
    r = make_item(CMD_ADD, 8'd255);
    r.hop_count = 8'd5;
    r.signal_rssi = 16'sh7FFF;
    send_item(r);
    r = make_item(CMD_FIND, 8'd254);
    send_item(r);
    r = make_item(CMD_DELETE, 8'd0);
    r.entry_index = 4'd15;
    send_item(r);
    r.entry_index = 4'd15;
    send_item(r);
    r.entry_index = 4'd0;
    send_item(r);
    clock_now = 32'd70000;
    r = make_item(CMD_FIND, 8'd1);
    send_item(r);
    r = make_item(CMD_PRUNE, 8'd0);
    send_item(r);
    drain();
    write_reg(REG_OWN_NODE, 32'd255);
    write_reg(REG_TIMEOUT, 32'd0);
    random_phase(150, 8'd20);
    drain();
    write_reg(REG_OWN_NODE, 32'd3);
    write_reg(REG_TIMEOUT, 32'd300);
    send_idle = 72;
    random_phase(300, 8'd24);
    drain();
    write_reg(REG_OWN_NODE, 32'd0);
    write_reg(REG_TIMEOUT, 32'hFFFF_FFFF);
    send_idle = 0;
    recv_stall = 72;
    random_phase(300, 8'd30);
    drain();
    write_reg(REG_OWN_NODE, 32'd7);
    write_reg(REG_TIMEOUT, 32'd120);
    send_idle = 24;
    recv_stall = 24;
    random_phase(350, 8'd15);
    drain();
    write_reg(REG_TIMEOUT, 32'd60000);
    send_idle = 0;
    recv_stall = 0;
    random_phase(325, 8'd40);
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
